[hw/rtl/cfs_pkg.sv]
// Shared types, constants and register codes for the conveyor feeder sequencer.
package cfs_pkg;

	localparam int unsigned TickW = 16;
	localparam int unsigned CfgIdxW = 2;

	typedef logic [TickW-1:0] tick_t;
	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	// Register indexes of the configuration port
	localparam cfg_idx_t CFG_LOCKOUT = 2'd0;
	localparam cfg_idx_t CFG_REJECT_HOLD = 2'd1;
	localparam cfg_idx_t CFG_FEED_TIMEOUT = 2'd2;
	localparam cfg_idx_t CFG_REJECT_TIMEOUT = 2'd3;

	// Register reset values
	localparam tick_t LOCKOUT_RST = 16'd2000;
	localparam tick_t REJECT_HOLD_RST = 16'd2000;
	localparam tick_t FEED_TIMEOUT_RST = 16'd2000;
	localparam tick_t REJECT_TIMEOUT_RST = 16'd5000;

	typedef struct packed {
		tick_t lockout_ticks;
		tick_t reject_hold_ticks;
		tick_t feed_timeout_ticks;
		tick_t reject_timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic  motor_state;
		logic  reverse_state;
		logic  feeding_flag;
		logic  rejecting_flag;
		tick_t lockout_elapsed;
		tick_t clear_elapsed;
		tick_t run_elapsed;
		logic  last_reject_sensor;
		logic  last_feed_sensor;
		logic  last_entry_sensor;
	} seq_state_t;

	typedef struct packed {
		logic emergency_stop;
		logic feeder_sensor;
		logic entry_sensor;
		logic reject_req;
		logic proc_busy;
	} tick_item_t;

	localparam tick_t TICK_MAX = {TickW{1'b1}};

	// Saturating tick counter increment
	function automatic tick_t sat_inc(input tick_t v);
		return (v == TICK_MAX) ? v : tick_t'(v + 1'b1);
	endfunction

endpackage

[hw/rtl/cfs_if.sv]
// Valid/ready channel interfaces for tick items and result items.
interface cfs_tick_if;
	logic valid;
	logic ready;
	logic emergency_stop;
	logic feeder_sensor;
	logic entry_sensor;
	logic reject_req;
	logic proc_busy;

	modport source (
		output valid, emergency_stop, feeder_sensor, entry_sensor, reject_req,
			proc_busy,
		input ready
	);
	modport sink (
		input valid, emergency_stop, feeder_sensor, entry_sensor, reject_req,
			proc_busy,
		output ready
	);
endinterface

interface cfs_result_if;
	logic valid;
	logic ready;
	logic motor_on;
	logic motor_reverse;
	logic feed_active;
	logic rejecting;

	modport source (
		output valid, motor_on, motor_reverse, feed_active, rejecting,
		input ready
	);
	modport sink (
		input valid, motor_on, motor_reverse, feed_active, rejecting,
		output ready
	);
endinterface

[hw/rtl/cfs_step.sv]
// Next-state logic of the sequencer for one tick item.
module cfs_step
	import cfs_pkg::*;
(
	input  cfg_t       cfg,
	input  seq_state_t cur,
	input  tick_item_t item,
	output seq_state_t nxt
);

	tick_t limit;
	logic  rej_active;
	seq_state_t s;

	always_comb begin
		s = cur;
		rej_active = 1'b0;
		limit = item.reject_req ? cfg.reject_timeout_ticks : cfg.feed_timeout_ticks;

		// Advance all tick counters
		s.lockout_elapsed = sat_inc(cur.lockout_elapsed);
		s.clear_elapsed = sat_inc(cur.clear_elapsed);
		s.run_elapsed = sat_inc(cur.run_elapsed);

		if (item.emergency_stop) begin
			// Drop both flags and stop the motor
			s.feeding_flag = 1'b0;
			s.rejecting_flag = 1'b0;
			s.motor_state = 1'b0;
			s.reverse_state = 1'b0;
		end else begin
			// Run timeout
			if (!s.motor_state) begin
				s.run_elapsed = '0;
			end
			if (s.run_elapsed >= limit) begin
				s.feeding_flag = 1'b0;
				s.rejecting_flag = 1'b0;
				s.motor_state = 1'b0;
				s.reverse_state = 1'b0;
			end

			// Rejection sequence, skipped during lockout
			if (s.lockout_elapsed >= cfg.lockout_ticks) begin
				if (item.reject_req) begin
					s.rejecting_flag = 1'b1;
				end
				if (s.rejecting_flag) begin
					rej_active = 1'b1;
					if (item.feeder_sensor) begin
						s.clear_elapsed = '0;
					end
					if (s.clear_elapsed < cfg.reject_hold_ticks) begin
						s.motor_state = 1'b0;
						s.reverse_state = 1'b0;
					end else begin
						s.motor_state = 1'b1;
						s.reverse_state = 1'b1;
					end
					if (item.feeder_sensor != s.last_reject_sensor) begin
						s.last_reject_sensor = item.feeder_sensor;
						if (!item.feeder_sensor) begin
							s.lockout_elapsed = '0;
							s.rejecting_flag = 1'b0;
							s.motor_state = 1'b0;
							s.reverse_state = 1'b0;
						end
					end
				end
			end

			// Normal feeding and entry detection
			if (!rej_active) begin
				if (item.proc_busy) begin
					s.motor_state = 1'b0;
					s.reverse_state = 1'b0;
				end else if (item.feeder_sensor != s.last_feed_sensor) begin
					s.last_feed_sensor = item.feeder_sensor;
					if (item.feeder_sensor) begin
						s.motor_state = 1'b1;
						s.reverse_state = 1'b0;
						s.feeding_flag = 1'b1;
					end
				end
				if (item.entry_sensor != s.last_entry_sensor) begin
					s.last_entry_sensor = item.entry_sensor;
					if (s.feeding_flag && !item.entry_sensor) begin
						s.motor_state = 1'b0;
						s.reverse_state = 1'b0;
						s.feeding_flag = 1'b0;
					end
				end
			end
		end
		nxt = s;
	end

endmodule

[hw/rtl/conveyor_feeder_sequencer_core.sv]
// Conveyor feeder sequencer: one tick item in, one drive result item out.
// The result of an item is in the result register in the cycle after acceptance.
// Throughput: one item per cycle while result.ready is high; the state registers update on each accepted item.
// The block accepts a new item whenever the result register is empty or being taken.
// Reset (arst_n low, asynchronous) clears the sequencer state, counters and result valid flag, loads the register
// defaults (lockout 2000, hold 2000, feed timeout 2000, reject timeout 5000).
module conveyor_feeder_sequencer_core
	import cfs_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  cfg_idx_t       cfg_index,
	input  tick_t          cfg_data,
	cfs_tick_if.sink       tick,
	cfs_result_if.source   result
);

	cfg_t       cfg_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	tick_item_t item;
	logic       accept;
	logic       res_valid_q;
	logic       motor_on_q;
	logic       motor_reverse_q;
	logic       feed_active_q;
	logic       rejecting_q;

	assign item = '{
		emergency_stop: tick.emergency_stop,
		feeder_sensor:  tick.feeder_sensor,
		entry_sensor:   tick.entry_sensor,
		reject_req:     tick.reject_req,
		proc_busy:      tick.proc_busy
	};

	// Take an item when the result register is free or drains this cycle
	assign tick.ready = !res_valid_q || result.ready;
	assign accept = tick.valid && tick.ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lockout_ticks <= LOCKOUT_RST;
			cfg_q.reject_hold_ticks <= REJECT_HOLD_RST;
			cfg_q.feed_timeout_ticks <= FEED_TIMEOUT_RST;
			cfg_q.reject_timeout_ticks <= REJECT_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOCKOUT:        cfg_q.lockout_ticks <= cfg_data;
				CFG_REJECT_HOLD:    cfg_q.reject_hold_ticks <= cfg_data;
				CFG_FEED_TIMEOUT:   cfg_q.feed_timeout_ticks <= cfg_data;
				CFG_REJECT_TIMEOUT: cfg_q.reject_timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	cfs_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item),
		.nxt  (state_nxt)
	);

	// Advance the sequencer state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			motor_on_q <= state_nxt.motor_state;
			motor_reverse_q <= state_nxt.motor_state && state_nxt.reverse_state;
			feed_active_q <= state_nxt.feeding_flag;
			rejecting_q <= state_nxt.rejecting_flag;
		end
	end

	assign result.valid = res_valid_q;
	assign result.motor_on = motor_on_q;
	assign result.motor_reverse = motor_reverse_q;
	assign result.feed_active = feed_active_q;
	assign result.rejecting = rejecting_q;

endmodule
